@@ rtl/barometric_pressure_compensation_defines.svh @@
// Assertion macros shared by the pressure compensation pipeline.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
`define BPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/bpc_pkg.sv @@
// Package with types and constants of the pressure compensation block.
package bpc_pkg;
    localparam int unsigned DivBits = 32;
    localparam logic [2:0] RegAc123 = 3'd0;
    localparam logic [2:0] RegAc456 = 3'd1;
    localparam logic [2:0] RegBmcmd = 3'd2;
    localparam logic [2:0] RegOss   = 3'd3;
    localparam logic [2:0] RegOffs  = 3'd4;

    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
        asr32 = 32'($signed(v) >>> n);
    endfunction
endpackage

@@ rtl/bpc_if.sv @@
// Valid/ready channel interface carrying a generic payload.
interface bpc_if #(parameter int unsigned W = 1) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/bpc_udiv.sv @@
// Pipelined unsigned 32-bit divider, one quotient bit per stage, with side payload.
module bpc_udiv #(
    parameter int unsigned SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [31:0]   i_num,
    input  logic [31:0]   i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [31:0]   o_quo,
    output logic [SW-1:0] o_side
);
    localparam int unsigned N = bpc_pkg::DivBits;
    logic [N:0]   r_v;
    logic [31:0]  r_q [N+1];
    logic [31:0]  r_r [N+1];
    logic [31:0]  r_d [N+1];
    logic [SW-1:0] r_s [N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_num;
            r_r[0] <= '0;
            r_d[0] <= i_den;
            r_s[0] <= i_side;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_st
        logic [32:0] n_sh;
        logic [33:0] n_df;
        assign n_sh = {r_r[k], r_q[k][31]};
        assign n_df = {1'b0, n_sh} - {2'b0, r_d[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1] <= {r_q[k][30:0], ~n_df[33]};
                r_r[k+1] <= n_df[33] ? n_sh[31:0] : n_df[31:0];
                r_d[k+1] <= r_d[k];
                r_s[k+1] <= r_s[k];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_quo   = r_q[N];
    assign o_side  = r_s[N];
endmodule

@@ rtl/bpc_temp.sv @@
// Temperature front end: X1, signed B5 division setup and result.
module bpc_temp (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [15:0]  i_ut,
    input  logic [18:0]  i_up,
    input  logic [15:0]  i_ac5,
    input  logic [15:0]  i_ac6,
    input  logic [15:0]  i_mc,
    input  logic [15:0]  i_md,
    output logic         o_valid,
    output logic [31:0]  o_b5,
    output logic [18:0]  o_up,
    output logic         o_err
);
    localparam int unsigned SW = 32 + 19 + 3;
    logic        r_v1;
    logic [31:0] r_prod;
    logic [18:0] r_up1;
    logic [31:0] n_x1, n_den, n_num, n_an, n_ad;
    logic        n_neg, n_zero;
    logic        r_v2;
    logic [31:0] r_x1, r_an, r_ad;
    logic [18:0] r_up2;
    logic        r_neg, r_zero;
    logic        w_dv;
    logic [31:0] w_q;
    logic [SW-1:0] w_side;
    logic [31:0] w_x1, w_x2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 32'(({16'b0, i_ut} - {16'b0, i_ac6}) * {16'b0, i_ac5});
            r_up1  <= i_up;
            r_x1   <= n_x1;
            r_an   <= n_an;
            r_ad   <= n_ad;
            r_up2  <= r_up1;
            r_neg  <= n_neg;
            r_zero <= n_zero;
        end
    end

    always_comb begin
        n_x1   = bpc_pkg::asr32(r_prod, 15);
        n_den  = n_x1 + {{16{i_md[15]}}, i_md};
        n_num  = {{5{i_mc[15]}}, i_mc, 11'b0};
        n_zero = (n_den == '0);
        n_neg  = n_num[31] ^ n_den[31];
        n_an   = n_num[31] ? -n_num : n_num;
        n_ad   = n_den[31] ? -n_den : n_den;
    end

    bpc_udiv #(.SW(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v2),
        .i_num   (r_an),
        .i_den   (r_ad),
        .i_side  ({r_x1, r_up2, r_neg, r_zero, 1'b0}),
        .o_valid (w_dv),
        .o_quo   (w_q),
        .o_side  (w_side)
    );

    assign w_x1 = w_side[SW-1 -: 32];
    assign w_x2 = w_side[2] ? -w_q : w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_b5  <= w_x1 + w_x2;
            o_up  <= w_side[21:3];
            o_err <= w_side[1];
        end
    end
endmodule

@@ rtl/bpc_press.sv @@
// Pressure back end: B3/B4/B7 polynomial, unsigned division and correction.
`include "barometric_pressure_compensation_defines.svh"
module bpc_press (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [31:0]  i_b5,
    input  logic [18:0]  i_up,
    input  logic         i_err,
    input  logic [47:0]  i_c123,
    input  logic [47:0]  i_c456,
    input  logic [63:0]  i_cb,
    input  logic [1:0]   i_oss,
    input  logic [31:0]  i_offs,
    output logic         o_valid,
    output logic [31:0]  o_press,
    output logic [15:0]  o_temp,
    output logic         o_err
);
    localparam int unsigned SW = 16 + 2;
    logic [31:0] ac1, ac2, ac3, ac4, b1, b2;
    logic [31:0] n_b6, n_t32;
    logic [15:0] n_t;
    logic [1:0]  oss;

    assign ac1 = {{16{i_c123[47]}}, i_c123[47:32]};
    assign ac2 = {{16{i_c123[31]}}, i_c123[31:16]};
    assign ac3 = {{16{i_c123[15]}}, i_c123[15:0]};
    assign ac4 = {16'b0, i_c456[47:32]};
    assign b1  = {{16{i_cb[63]}}, i_cb[63:48]};
    assign b2  = {{16{i_cb[47]}}, i_cb[47:32]};
    assign oss = i_oss;

    always_comb begin
        n_b6  = i_b5 - 32'd4000;
        n_t32 = bpc_pkg::asr32(i_b5 + 32'd8, 4);
        if ($signed(n_t32) > 32'sd32767) begin
            n_t = 16'h7fff;
        end else if ($signed(n_t32) < -32'sd32768) begin
            n_t = 16'h8000;
        end else begin
            n_t = n_t32[15:0];
        end
        if (n_t == '0) begin
            n_t = 16'hffff;
        end
    end

    // Stage A: b6 squared and ac2/ac3 products.
    logic        r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg, r_vh, r_vi;
    logic [31:0] r_a_sq, r_a_p2, r_a_p3;
    logic [18:0] r_a_up;
    logic [15:0] r_a_t;
    logic        r_a_e;

    // Stage B: b2 and b1 products.
    logic [31:0] r_b_x2, r_b_x1a, r_b_p2, r_b_p1;
    logic [18:0] r_b_up;
    logic [15:0] r_b_t;
    logic        r_b_e;

    // Stage C: b3 and b4 product.
    logic [31:0] r_c_b3, r_c_b4;
    logic [18:0] r_c_up;
    logic [15:0] r_c_t;
    logic        r_c_e;

    // Stage D: b7.
    logic [31:0] r_d_b7, r_d_b4;
    logic [15:0] r_d_t;
    logic        r_d_e;

    logic [31:0] n_b6sq, n_x3b, n_b3, n_x3c, n_b4, n_b7s, n_num;
    logic        n_big, n_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    always_comb begin
        n_b6sq = bpc_pkg::asr32(r_a_sq, 12);
        n_x3b  = bpc_pkg::asr32(r_b_p2, 11) + r_b_x2;
        n_b3   = bpc_pkg::asr32(((ac1 << 2) + n_x3b) << oss, 0) + 32'd2;
        n_b3   = bpc_pkg::asr32(n_b3, 2);
        n_x3c  = bpc_pkg::asr32(r_b_x1a + bpc_pkg::asr32(r_b_p1, 16) + 32'd2, 2);
        n_b4   = r_c_b4 >> 15;
        n_b7s  = ({13'b0, r_c_up} - r_c_b3);
        n_big  = r_d_b7[31];
        n_num  = n_big ? r_d_b7 : {r_d_b7[30:0], 1'b0};
        n_e    = r_d_e | (r_d_b4 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_sq  <= 32'(n_b6 * n_b6);
            r_a_p2  <= 32'(ac2 * n_b6);
            r_a_p3  <= 32'(ac3 * n_b6);
            r_a_up  <= i_up;
            r_a_t   <= n_t;
            r_a_e   <= i_err;

            r_b_x2  <= bpc_pkg::asr32(r_a_p2, 11);
            r_b_x1a <= bpc_pkg::asr32(r_a_p3, 13);
            r_b_p2  <= 32'(b2 * n_b6sq);
            r_b_p1  <= 32'(b1 * n_b6sq);
            r_b_up  <= r_a_up;
            r_b_t   <= r_a_t;
            r_b_e   <= r_a_e;

            r_c_b3  <= n_b3;
            r_c_b4  <= 32'(ac4 * (n_x3c + 32'd32768));
            r_c_up  <= r_b_up;
            r_c_t   <= r_b_t;
            r_c_e   <= r_b_e;

            r_d_b7  <= 32'(n_b7s * (32'd50000 >> oss));
            r_d_b4  <= n_b4;
            r_d_t   <= r_c_t;
            r_d_e   <= r_c_e;
        end
    end

    logic          w_dv;
    logic [31:0]   w_q;
    logic [SW-1:0] w_s;

    bpc_udiv #(.SW(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_vd),
        .i_num   (n_num),
        .i_den   (r_d_b4),
        .i_side  ({r_d_t, n_big, n_e}),
        .o_valid (w_dv),
        .o_quo   (w_q),
        .o_side  (w_s)
    );

    // Stage F..I: correction polynomial.
    logic [31:0] r_f_p, r_f_p8;
    logic [31:0] r_g_p, r_g_sq, r_g_m;
    logic [31:0] r_h_p, r_h_x1p, r_h_x2;
    logic [15:0] r_f_t, r_g_t, r_h_t, r_i_t;
    logic        r_f_e, r_g_e, r_h_e, r_i_e;
    logic [31:0] n_p, n_pr, r_i_pr;

    assign n_p  = w_s[1] ? {w_q[30:0], 1'b0} : w_q;
    assign n_pr = r_h_p + bpc_pkg::asr32(bpc_pkg::asr32(r_h_x1p, 16) + r_h_x2 + 32'd3791, 4)
                  - i_offs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
            r_vg <= 1'b0;
            r_vh <= 1'b0;
            r_vi <= 1'b0;
        end else if (i_en) begin
            r_vf <= w_dv;
            r_vg <= r_vf;
            r_vh <= r_vg;
            r_vi <= r_vh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_p   <= n_p;
            r_f_p8  <= bpc_pkg::asr32(n_p, 8);
            r_f_t   <= w_s[SW-1 -: 16];
            r_f_e   <= w_s[0];
            r_g_p   <= r_f_p;
            r_g_sq  <= 32'(r_f_p8 * r_f_p8);
            r_g_m   <= 32'(32'hffffe343 * r_f_p);
            r_g_t   <= r_f_t;
            r_g_e   <= r_f_e;
            r_h_p   <= r_g_p;
            r_h_x1p <= 32'(r_g_sq * 32'd3038);
            r_h_x2  <= bpc_pkg::asr32(r_g_m, 16);
            r_h_t   <= r_g_t;
            r_h_e   <= r_g_e;
            r_i_pr  <= n_pr;
            r_i_t   <= r_h_t;
            r_i_e   <= r_h_e;
        end
    end

    assign o_valid = r_vi;
    assign o_err   = r_i_e;
    assign o_press = r_i_e ? 32'hffffffff : ((r_i_pr == '0) ? 32'hffffffff : r_i_pr);
    assign o_temp  = r_i_e ? 16'hffff : r_i_t;

    `BPC_ASSERT_IMPL(a_err_out, i_clk, i_rst_n, o_valid && o_err,
        o_press == 32'hffffffff && o_temp == 16'hffff)
    `BPC_ASSERT_IMPL(a_nz, i_clk, i_rst_n, o_valid, o_press != '0 && o_temp != '0)
    `BPC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !i_en && o_valid, o_valid)
endmodule

@@ rtl/barometric_pressure_compensation.sv @@
// Top level of the pipelined barometric pressure compensation block.
// Channel | Dir | Payload
// in_ch   | in  | raw_temp[15:0], raw_press[18:0]
// out_ch  | out | pressure_pa[31:0], temp_tenths[15:0], div_error
// One beat enters per cycle while the pipeline advances; the temperature and pressure
// paths each hold one of the two 33-stage dividers.
// The pipeline advances whenever the output register is empty or being taken.
// A stall freezes every stage, so nothing is lost or repeated.
// Reset clears all valid bits and configuration registers to zero.
`include "barometric_pressure_compensation_defines.svh"
module barometric_pressure_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    bpc_if.sink         in_ch,
    bpc_if.source       out_ch
);
    logic [47:0] r_c123, r_c456;
    logic [63:0] r_cb;
    logic [1:0]  r_oss;
    logic [31:0] r_offs;
    logic        w_en, w_tv, w_te, w_pv, w_pe;
    logic [31:0] w_b5, w_pr;
    logic [18:0] w_up;
    logic [15:0] w_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c123 <= '0;
            r_c456 <= '0;
            r_cb   <= '0;
            r_oss  <= '0;
            r_offs <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpc_pkg::RegAc123: r_c123 <= i_cfg_data[47:0];
                bpc_pkg::RegAc456: r_c456 <= i_cfg_data[47:0];
                bpc_pkg::RegBmcmd: r_cb   <= i_cfg_data;
                bpc_pkg::RegOss:   r_oss  <= i_cfg_data[1:0];
                bpc_pkg::RegOffs:  r_offs <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign w_en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = w_en;

    bpc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (in_ch.valid),
        .i_ut    (in_ch.data[15:0]),
        .i_up    (in_ch.data[34:16]),
        .i_ac5   (r_c456[31:16]),
        .i_ac6   (r_c456[15:0]),
        .i_mc    (r_cb[31:16]),
        .i_md    (r_cb[15:0]),
        .o_valid (w_tv),
        .o_b5    (w_b5),
        .o_up    (w_up),
        .o_err   (w_te)
    );

    bpc_press u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_tv),
        .i_b5    (w_b5),
        .i_up    (w_up),
        .i_err   (w_te),
        .i_c123  (r_c123),
        .i_c456  (r_c456),
        .i_cb    (r_cb),
        .i_oss   (r_oss),
        .i_offs  (r_offs),
        .o_valid (w_pv),
        .o_press (w_pr),
        .o_temp  (w_t),
        .o_err   (w_pe)
    );

    assign out_ch.valid = w_pv;
    assign out_ch.data  = {w_pe, w_t, w_pr};

    `BPC_ASSERT_IMPL(a_rdy, i_clk, i_rst_n, out_ch.valid && !out_ch.ready, !in_ch.ready)
    `BPC_ASSERT_NEXT(a_stall, i_clk, i_rst_n, out_ch.valid && !out_ch.ready,
        $stable(out_ch.data))
endmodule

@@ verif/bpc_checker.sv @@
// Checker that predicts each compensated reading and compares it on the output channel.
`timescale 1ns / 100ps
module bpc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    bpc_if              in_ch,
    bpc_if              out_ch,
    output int          o_errors,
    output int          o_pending
);
    typedef struct packed {
        logic        err;
        logic [15:0] tenths;
        logic [31:0] pa;
    } t_reading;

    logic [47:0] ac_signed;
    logic [47:0] ac_unsigned;
    logic [63:0] b_mc_md;
    logic [1:0]  oss;
    logic [31:0] offs;
    t_reading    reading_q[$];
    int          errors;

    assign o_errors  = errors;
    assign o_pending = reading_q.size();

    function automatic logic [31:0] sar(input logic [31:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [31:0] sx(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic t_reading compensate(input logic [15:0] ut16, input logic [18:0] up19);
        logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, den, b3, b4, b5, b6, b6sq, b7, p, pr;
        int          t;
        t_reading    r;
        ut  = {16'b0, ut16};
        up  = {13'b0, up19};
        ac1 = sx(ac_signed[47:32]);
        ac2 = sx(ac_signed[31:16]);
        ac3 = sx(ac_signed[15:0]);
        ac4 = {16'b0, ac_unsigned[47:32]};
        ac5 = {16'b0, ac_unsigned[31:16]};
        ac6 = {16'b0, ac_unsigned[15:0]};
        b1  = sx(b_mc_md[63:48]);
        b2  = sx(b_mc_md[47:32]);
        mc  = sx(b_mc_md[31:16]);
        md  = sx(b_mc_md[15:0]);
        r.pa = 32'hFFFF_FFFF;
        r.tenths = 16'hFFFF;
        r.err = 1'b1;
        x1 = (ut - ac6) * ac5;
        x1 = sar(x1, 15);
        den = x1 + md;
        if (den == 32'd0) return r;
        x2 = mc << 11;
        x2 = $signed(x2) / $signed(den);
        b5 = x1 + x2;
        t = $signed(sar(b5 + 32'd8, 4));
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        if (t == 0) t = -1;
        b6 = b5 - 32'd4000;
        b6sq = b6 * b6;
        b6sq = sar(b6sq, 12);
        x1 = b2 * b6sq;
        x2 = ac2 * b6;
        x3 = sar(x1, 11) + sar(x2, 11);
        b3 = ((ac1 * 32'd4 + x3) << oss) + 32'd2;
        b3 = sar(b3, 2);
        x1 = ac3 * b6;
        x2 = b1 * b6sq;
        x3 = sar(sar(x1, 13) + sar(x2, 16) + 32'd2, 2);
        x3 = x3 + 32'd32768;
        b4 = ac4 * x3;
        b4 = b4 >> 15;
        if (b4 == 32'd0) return r;
        b7 = (up - b3) * (32'd50000 >> oss);
        if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        x1 = sar(p, 8) * sar(p, 8);
        x1 = x1 * 32'd3038;
        x1 = sar(x1, 16);
        x2 = 32'hFFFF_E343 * p;
        x2 = sar(x2, 16);
        pr = p + sar(x1 + x2 + 32'd3791, 4);
        pr = pr - offs;
        if (pr == 32'd0) pr = 32'hFFFF_FFFF;
        r.pa = pr;
        r.tenths = t[15:0];
        r.err = 1'b0;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("ERROR at %0t: %s is %h, expected %h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_reading got, want;
        if (!i_rst_n) begin
            ac_signed = '0;
            ac_unsigned = '0;
            b_mc_md = '0;
            oss = '0;
            offs = '0;
            reading_q.delete();
            errors = 0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                reading_q.push_back(compensate(in_ch.data[15:0], in_ch.data[34:16]));
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (reading_q.size() == 0) begin
                    report("unexpected beat", got.pa, 32'd0);
                end else begin
                    want = reading_q.pop_front();
                    if (got.pa !== want.pa) report("pressure_pa", got.pa, want.pa);
                    if (got.tenths !== want.tenths)
                        report("temp_tenths", {16'b0, got.tenths}, {16'b0, want.tenths});
                    if (got.err !== want.err)
                        report("div_error", {31'b0, got.err}, {31'b0, want.err});
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bpc_pkg::RegAc123: ac_signed = i_cfg_data[47:0];
                    bpc_pkg::RegAc456: ac_unsigned = i_cfg_data[47:0];
                    bpc_pkg::RegBmcmd: b_mc_md = i_cfg_data;
                    bpc_pkg::RegOss:   oss = i_cfg_data[1:0];
                    bpc_pkg::RegOffs:  offs = i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

@@ verif/testbench.sv @@
// Top of the testbench: clock, reset, stimulus, output stalls, watchdog and verdict.
`timescale 1ns / 100ps
module testbench;
    localparam logic [2:0]  RegUnused = 3'd7;
    localparam logic [47:0] DsAc123 = {16'd408, 16'hFFB8, 16'hC7D1};
    localparam logic [47:0] DsAc456 = {16'h7FE5, 16'h7FF5, 16'h5A71};
    localparam logic [63:0] DsBmcmd = {16'h182E, 16'h0004, 16'hDDF9, 16'h0B34};
    localparam int          IdleLimit = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;
    int          errors;
    int          pending;
    int          idle_cycles;
    bit          hold_req;
    bit          src_steady;

    bpc_if #(.W(35)) in_ch ();
    bpc_if #(.W(49)) out_ch ();

    barometric_pressure_compensation u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    bpc_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        int skip;
        skip = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (skip > 0) begin
                out_ch.ready <= 1'b0;
                skip--;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 5) == 0) skip = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [47:0] ac123, input logic [47:0] ac456,
                             input logic [63:0] bmcmd, input logic [1:0] os,
                             input logic [31:0] offset);
        cfg_write(bpc_pkg::RegAc123, {16'b0, ac123});
        cfg_write(bpc_pkg::RegAc456, {16'b0, ac456});
        cfg_write(bpc_pkg::RegBmcmd, bmcmd);
        cfg_write(bpc_pkg::RegOss, {62'b0, os});
        cfg_write(bpc_pkg::RegOffs, {32'b0, offset});
        i_cfg_we <= 1'b0;
    endtask

    task automatic send(input logic [15:0] ut, input logic [18:0] up);
        bit taken;
        if (!src_steady && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {up, ut};
        do begin
            @(negedge i_clk);
            taken = in_ch.ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (90) @(posedge i_clk);
    endtask

    initial begin
        hold_req = 1'b0;
        src_steady = 1'b0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset coefficients leave the temperature divisor at zero.
        send(16'd27898, 19'd23843);
        send(16'hFFFF, 19'h7FFFF);
        drain();

        cfg_write(RegUnused, '1);
        configure(DsAc123, DsAc456, DsBmcmd, 2'd0, 32'd0);
        send(16'd27898, 19'd23843);
        send(16'd0, 19'd0);
        send(16'hFFFF, 19'h7FFFF);
        send(16'd0, 19'h7FFFF);
        send(16'hFFFF, 19'd0);
        send(16'h5555, 19'h2AAAA);
        send(16'hAAAA, 19'h55555);
        drain();

        // A zero AC4 makes the pressure divisor zero.
        configure(DsAc123, {16'd0, DsAc456[31:0]}, DsBmcmd, 2'd3, 32'd100);
        send(16'd27898, 19'd23843);
        send(16'd30000, 19'd90000);
        drain();

        // Minimal coefficients give a zero temperature and, with this offset,
        // a zero pressure at a zero reading; both become -1.
        configure(48'd0, {16'd1, 16'd0, 16'd0}, 64'd1, 2'd0, 32'd236);
        send(16'd0, 19'd0);
        send(16'd1234, 19'd0);
        send(16'd0, 19'd1);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: configure('1, '1, '1, 2'd3, 32'h8000_0000);
                1: configure(DsAc123, DsAc456, DsBmcmd, 2'd3, 32'h7FFF_FFFF);
                2: configure(DsAc123, DsAc456, DsBmcmd, 2'd1, $urandom);
                default: configure(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                   {$urandom, $urandom}, 2'($urandom), $urandom);
            endcase
            src_steady = (ph % 2) == 1;
            for (int n = 0; n < 180; n++) begin
                if (ph == 2 && n == 20) hold_req = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    send(16'($urandom_range(24000, 34000)), 19'($urandom_range(20000, 200000)));
                else
                    send(16'($urandom), 19'($urandom));
            end
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
